### rtl/kft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kft_pkg
// Shared types and constants of the k-mer frequency table.
// ----------------------------------------------------------------------------
package kft_pkg;

  localparam int unsigned TableDepthDefault = 4096;
  localparam int unsigned KmerLengthDefault = 5;
  localparam int unsigned CharFields        = 5;
  localparam int unsigned SymW              = 15;
  localparam int unsigned FreqW             = 32;

  typedef enum logic [2:0] {
    OpAppend = 3'd0,
    OpInsert = 3'd1,
    OpDelete = 3'd2,
    OpRead   = 3'd3,
    OpFind   = 3'd4,
    OpSort   = 3'd5,
    OpMerge  = 3'd6,
    OpCount  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StBadPos   = 2'd2,
    StNotFound = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    SIdle, SShiftUp, SShiftDn, SRead, SFind, SSortScan, SSortSwap,
    SMergeScan, SZeroScan, SCount, SWait, SDone
  } state_e;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic              we;
    logic [15:0]       waddr;
    logic [SymW-1:0]   wsym;
    logic [FreqW-1:0]  wfreq;
    logic [15:0]       raddr;
  } mem_req_t;

  function automatic logic [2:0] code_of(input logic [7:0] c);
    logic [7:0] l;
    l = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    case (l)
      8'h61:   code_of = 3'd1;
      8'h74:   code_of = 3'd2;
      8'h67:   code_of = 3'd3;
      8'h63:   code_of = 3'd4;
      default: code_of = 3'd0;
    endcase
  endfunction

  function automatic logic [FreqW-1:0] sat_add(input logic [FreqW-1:0] a,
                                               input logic [FreqW-1:0] b);
    logic [FreqW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[FreqW] ? '1 : s[FreqW-1:0];
  endfunction

endpackage

### rtl/kft_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kft_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kft_mem #(
  parameter int unsigned Depth = kft_pkg::TableDepthDefault,
  parameter int unsigned AW    = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  kft_pkg::mem_req_t      req_i,
  output logic [kft_pkg::SymW-1:0]  rsym_o,
  output logic [kft_pkg::FreqW-1:0] rfreq_o
);
  import kft_pkg::*;

  logic [SymW+FreqW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= {req_i.wsym, req_i.wfreq};
    end
    {rsym_o, rfreq_o} <= mem[req_i.raddr[AW-1:0]];
  end

endmodule

### rtl/kft_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kft_seq
// Operation sequencer: walks the entry store for one command at a time.
// ----------------------------------------------------------------------------
module kft_seq #(
  parameter int unsigned Depth = kft_pkg::TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        hold_i,
  input  logic [2:0]  op_i,
  input  logic [kft_pkg::SymW-1:0]  sym_i,
  input  logic [kft_pkg::FreqW-1:0] freq_i,
  input  logic [12:0] pos_i,
  input  logic [31:0] thr_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [11:0] index_o,
  output logic [kft_pkg::SymW-1:0]  sym_o,
  output logic [kft_pkg::FreqW-1:0] freq_o,
  output logic [12:0] count_o,
  output kft_pkg::mem_req_t req_o,
  input  logic [kft_pkg::SymW-1:0]  rsym_i,
  input  logic [kft_pkg::FreqW-1:0] rfreq_i
);
  import kft_pkg::*;

  localparam int unsigned CW = 17;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, w_q, w_d, best_q, best_d;
  logic [CW-1:0] n_q, n_d;
  logic [2:0]    op_q;
  logic [SymW-1:0]  sym_q, ks_q, ks_d;
  logic [FreqW-1:0] freq_q, kf_q, kf_d, bf_q, bf_d;
  logic [CW-1:0] pos_q;
  logic [31:0]   thr_q;
  logic          rv_q, rv_d;     // read data valid this cycle
  logic [CW-1:0] ra_q, ra_d;     // address of data in flight
  logic [1:0]    st_q, st_d;
  logic [11:0]   ix_q, ix_d;
  logic [SymW-1:0]  os_q, os_d;
  logic [FreqW-1:0] of_q, of_d;
  logic          swp_q, swp_d;
  logic [SymW-1:0]  is_q, is_d;
  logic [FreqW-1:0] if_q, if_d;
  mem_req_t      req;
  logic [CW-1:0] dep;

  assign dep = CW'(Depth);
  assign busy_o   = state_q != SIdle;
  assign done_o   = (state_q == SDone) && !hold_i;
  assign status_o = st_q;
  assign index_o  = ix_q;
  assign sym_o    = os_q;
  assign freq_o   = of_q;
  assign count_o  = (op_q == OpCount) ? n_q[12:0] : cnt_q[12:0];
  assign req_o    = req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q <= op_i; sym_q <= sym_i; freq_q <= freq_i;
      pos_q <= CW'(pos_i); thr_q <= thr_i;
    end
    i_q <= i_d; j_q <= j_d; w_q <= w_d; best_q <= best_d; n_q <= n_d;
    ks_q <= ks_d; kf_q <= kf_d; bf_q <= bf_d; ra_q <= ra_d;
    st_q <= st_d; ix_q <= ix_d; os_q <= os_d; of_q <= of_d;
    swp_q <= swp_d; is_q <= is_d; if_q <= if_d;
  end

  // Every walk keeps one read in flight; a result is consumed in the cycle
  // after its address was issued.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; w_d = w_q;
    best_d = best_q; n_d = n_q; ks_d = ks_q; kf_d = kf_q; bf_d = bf_q;
    rv_d = 1'b0; ra_d = ra_q; st_d = st_q; ix_d = ix_q; os_d = os_q;
    of_d = of_q; swp_d = swp_q; is_d = is_q; if_d = if_q;
    req = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          st_d = StOk; ix_d = '0; os_d = '0; of_d = '0; n_d = '0;
          state_d = SDone;
          unique case (op_e'(op_i))
            OpAppend: begin
              if (cnt_q >= dep) st_d = StFull;
              else begin
                req.we = 1'b1; req.waddr = cnt_q[15:0];
                req.wsym = sym_i; req.wfreq = freq_i;
                cnt_d = cnt_q + 1'b1;
              end
            end
            OpInsert: begin
              if (cnt_q >= dep) st_d = StFull;
              else if (pos_i == 0 || CW'(pos_i) > cnt_q + 1'b1) st_d = StBadPos;
              else begin
                i_d = cnt_q; state_d = SShiftUp;
              end
            end
            OpDelete: begin
              if (CW'(pos_i) >= cnt_q) st_d = StBadPos;
              else begin i_d = CW'(pos_i); state_d = SShiftDn; end
            end
            OpRead: begin
              if (CW'(pos_i) >= cnt_q) st_d = StBadPos;
              else begin
                req.raddr = 16'(pos_i); rv_d = 1'b1; state_d = SRead;
              end
            end
            OpFind: begin
              if (CW'(pos_i) >= dep) st_d = StBadPos;
              else begin st_d = StNotFound; i_d = CW'(pos_i); state_d = SFind; end
            end
            OpSort: begin i_d = '0; j_d = '0; state_d = SSortScan; end
            OpMerge: begin
              i_d = '0; j_d = CW'(1); w_d = CW'(1); ra_d = '1;
              state_d = SMergeScan;
            end
            OpCount: begin i_d = '0; state_d = SCount; end
            default: ;
          endcase
        end
      end
      SShiftUp: begin
        // i walks down from count to slot; write entry i from i-1
        if (rv_q) begin
          req.we = 1'b1; req.waddr = 16'(ra_q + 1'b1);
          req.wsym = rsym_i; req.wfreq = rfreq_i;
        end
        if (i_q > pos_q - 1'b1) begin
          req.raddr = 16'(i_q - 1'b1); rv_d = 1'b1; ra_d = i_q - 1'b1;
          i_d = i_q - 1'b1;
        end else if (!rv_q) begin
          req.we = 1'b1; req.waddr = 16'(pos_q - 1'b1);
          req.wsym = sym_q; req.wfreq = freq_q;
          cnt_d = cnt_q + 1'b1; state_d = SDone;
        end
      end
      SShiftDn: begin
        if (rv_q) begin
          req.we = 1'b1; req.waddr = 16'(ra_q - 1'b1);
          req.wsym = rsym_i; req.wfreq = rfreq_i;
        end
        if (i_q + 1'b1 < cnt_q) begin
          req.raddr = 16'(i_q + 1'b1); rv_d = 1'b1; ra_d = i_q + 1'b1;
          i_d = i_q + 1'b1;
        end else if (!rv_q) begin
          cnt_d = cnt_q - 1'b1; state_d = SDone;
        end
      end
      SRead: begin
        ix_d = pos_q[11:0]; os_d = rsym_i; of_d = rfreq_i; state_d = SDone;
      end
      SFind: begin
        if (rv_q && rsym_i == sym_q) begin
          st_d = StOk; ix_d = ra_q[11:0]; os_d = rsym_i; of_d = rfreq_i;
          state_d = SDone;
        end else if (i_q < cnt_q) begin
          req.raddr = 16'(i_q); rv_d = 1'b1; ra_d = i_q; i_d = i_q + 1'b1;
        end else if (!rv_q) begin
          state_d = SDone;
        end
      end
      SSortScan: begin
        // j scans i..count-1 tracking the first maximum
        if (rv_q) begin
          if (ra_q == i_q) begin
            is_d = rsym_i; if_d = rfreq_i;
            best_d = ra_q; bf_d = rfreq_i; ks_d = rsym_i;
          end else if (rfreq_i > bf_q) begin
            best_d = ra_q; bf_d = rfreq_i; ks_d = rsym_i;
          end
        end
        if (i_q >= cnt_q) begin
          state_d = SDone;
        end else if (j_q < cnt_q) begin
          req.raddr = 16'(j_q); rv_d = 1'b1; ra_d = j_q; j_d = j_q + 1'b1;
        end else if (!rv_q) begin
          state_d = SSortSwap; swp_d = 1'b0;
        end
      end
      SSortSwap: begin
        if (!swp_q) begin
          req.we = 1'b1; req.waddr = 16'(i_q); req.wsym = ks_q; req.wfreq = bf_q;
          swp_d = 1'b1;
        end else begin
          req.we = 1'b1; req.waddr = 16'(best_q); req.wsym = is_q; req.wfreq = if_q;
          i_d = i_q + 1'b1; j_d = i_q + 1'b1; state_d = SSortScan;
        end
      end
      SMergeScan: begin
        // pass for anchor i: fetch anchor at j==i+1 first read
        if (rv_q) begin
          if (ra_q == i_q) begin
            ks_d = rsym_i; kf_d = rfreq_i;
          end else if (rsym_i == ks_q) begin
            kf_d = sat_add(kf_q, rfreq_i);
          end else begin
            req.we = 1'b1; req.waddr = 16'(w_q); req.wsym = rsym_i;
            req.wfreq = rfreq_i; w_d = w_q + 1'b1;
          end
        end
        if (i_q >= cnt_q) begin
          i_d = '0; w_d = '0; state_d = SZeroScan;
        end else if (j_q == i_q + 1'b1 && !(rv_q && ra_q == i_q) &&
                     !(rv_q && ra_q > i_q) && ra_q != i_q) begin
          req.raddr = 16'(i_q); rv_d = 1'b1; ra_d = i_q;
        end else if (j_q < cnt_q) begin
          req.raddr = 16'(j_q); rv_d = 1'b1; ra_d = j_q; j_d = j_q + 1'b1;
        end else if (!rv_q) begin
          if (!req.we) begin
            req.we = 1'b1; req.waddr = 16'(i_q); req.wsym = ks_q; req.wfreq = kf_q;
          end
          cnt_d = w_q; i_d = i_q + 1'b1; j_d = i_q + 2'd2; w_d = i_q + 2'd2;
          ra_d = '1;
        end
      end
      SZeroScan: begin
        if (rv_q && rfreq_i != '0) begin
          req.we = 1'b1; req.waddr = 16'(w_q); req.wsym = rsym_i;
          req.wfreq = rfreq_i; w_d = w_q + 1'b1;
        end
        if (i_q < cnt_q) begin
          req.raddr = 16'(i_q); rv_d = 1'b1; ra_d = i_q; i_d = i_q + 1'b1;
        end else if (!rv_q) begin
          cnt_d = w_d; state_d = SDone;
        end
      end
      SCount: begin
        if (rv_q && rfreq_i >= thr_q) n_d = n_q + 1'b1;
        if (i_q < cnt_q) begin
          req.raddr = 16'(i_q); rv_d = 1'b1; ra_d = i_q; i_d = i_q + 1'b1;
        end else if (!rv_q) begin
          state_d = SDone;
        end
      end
      SWait: state_d = SDone;
      SDone: begin
        // hold the finished result until the output register is free
        if (!hold_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

### rtl/kmer_frequency_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_frequency_table_core
// Ordered k-mer table with frequencies; one result item per command item.
// ----------------------------------------------------------------------------
// Usage: a command item enters on the s_axis group; tdata carries the raw
// characters, the character count, frequency, position and threshold, tuser
// the opcode. One result item leaves on m_axis per command.
// Work per command: append and a rejected command need no walk; read
// issues a single registered read; insert, delete, find and count walk the
// entries once; merge and sort make one pass per anchor entry, merge then
// a pass that drops zero entries. The single read port of the entry store
// bounds how fast each walk goes.
// One command is processed at a time; a new command is taken once the
// previous one has finished and its result sits in the output register,
// even while that result is stalled.
// Reset clears the entry count; the store itself is not cleared, entries
// beyond the count are never read.
// A stalled receiver holds the result register; the block waits for it
// before finishing the next command.
// ----------------------------------------------------------------------------
module kmer_frequency_table_core #(
  parameter int unsigned TableDepth = kft_pkg::TableDepthDefault,
  parameter int unsigned KmerLength = kft_pkg::KmerLengthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // char_0, char_1, char_2, char_3, char_4, char_count, frequency_in,
  // position, min_frequency (bits 0..119), zero fill
  input  logic [127:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, index_out, symbols_out, frequency_out, count_out (0..73), fill
  output logic [79:0]  m_axis_tdata
);
  import kft_pkg::*;

  logic [SymW-1:0]  sym_in, rsym, osym;
  logic [FreqW-1:0] freq_in, rfreq, ofreq;
  logic [2:0]  ccount;
  logic        busy, done, start, ov_q, hold;
  logic [1:0]  ost;
  logic [11:0] oix;
  logic [12:0] ocnt;
  logic [79:0] od_q;
  mem_req_t    req;

  assign ccount = s_axis_tdata[42:40];
  always_comb begin
    sym_in = '0;
    for (int k = 0; k < CharFields; k++) begin
      if (k < KmerLength && 3'(k) < ccount)
        sym_in[3*k +: 3] = code_of(s_axis_tdata[8*k +: 8]);
    end
  end
  assign freq_in = s_axis_tdata[74] ? '0 : s_axis_tdata[74:43];

  assign s_axis_tready = !busy;
  assign start = s_axis_tvalid && s_axis_tready;
  assign hold  = ov_q && !m_axis_tready;

  kft_mem #(.Depth(TableDepth)) u_mem (
    .clk_i, .req_i(req), .rsym_o(rsym), .rfreq_o(rfreq)
  );

  kft_seq #(.Depth(TableDepth)) u_seq (
    .clk_i, .rst_ni, .start_i(start), .hold_i(hold), .op_i(s_axis_tuser),
    .sym_i(sym_in), .freq_i(freq_in), .pos_i(s_axis_tdata[87:75]),
    .thr_i(s_axis_tdata[119:88]), .busy_o(busy), .done_o(done),
    .status_o(ost), .index_o(oix), .sym_o(osym), .freq_o(ofreq),
    .count_o(ocnt), .req_o(req), .rsym_i(rsym), .rfreq_i(rfreq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (done) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (done) od_q <= {6'd0, ocnt, ofreq, osym, oix, ost};
  end
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("accept while busy");
  a_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !ov_q || m_axis_tready) else $error("result overwritten");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the k-mer frequency table core.
// Drives command items in random bursts, stalls the result side on its own
// pattern, and checks each result item field by field against a behavioral
// copy of the table kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import kft_pkg::*;

  localparam int unsigned Depth = 4096;
  localparam int unsigned NumRandom = 140;

  typedef struct packed {
    logic [12:0] count;
    logic [31:0] frequency;
    logic [14:0] symbols;
    logic [11:0] index;
    logic [1:0]  status;
  } result_t;

  typedef struct {
    op_e         op;
    logic [7:0]  chars [5];
    logic [2:0]  nchars;
    logic [31:0] freq;
    logic [12:0] pos;
    logic [31:0] thresh;
    logic        has_fixed;
    result_t     fixed;
  } cmd_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;

  kmer_frequency_table_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench copy of the table.
  logic [14:0] tbl_sym  [Depth];
  logic [31:0] tbl_freq [Depth];
  int unsigned tbl_len;

  result_t     pending_results [$];
  cmd_t        directed_rows [$];
  int          errors = 0;
  int          results_seen = 0;
  bit          long_hold = 1'b0;
  int unsigned op_hits [8];

  function automatic logic [2:0] symbol_code(input logic [7:0] c);
    logic [7:0] l;
    l = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    case (l)
      "a":     return 3'd1;
      "t":     return 3'd2;
      "g":     return 3'd3;
      "c":     return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [14:0] kmer_key(input cmd_t c);
    logic [14:0] k;
    k = '0;
    for (int i = 0; i < 5; i++)
      if (i < c.nchars) k[3*i +: 3] = symbol_code(c.chars[i]);
    return k;
  endfunction

  function automatic logic [31:0] add_clip(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Apply one command to the bench table and return the result it produces.
  function automatic result_t table_step(input cmd_t c);
    result_t     r;
    logic [31:0] f;
    logic [14:0] ts;
    logic [31:0] tf;
    int unsigned best, w, n;
    r = '0;
    f = c.freq[31] ? 32'd0 : c.freq;
    case (c.op)
      OpAppend: begin
        if (tbl_len >= Depth) r.status = StFull;
        else begin
          tbl_sym[tbl_len] = kmer_key(c);
          tbl_freq[tbl_len] = f;
          tbl_len++;
        end
      end
      OpInsert: begin
        if (tbl_len >= Depth) r.status = StFull;
        else if (c.pos < 1 || c.pos > tbl_len + 1) r.status = StBadPos;
        else begin
          for (int i = tbl_len; i > c.pos - 1; i--) begin
            tbl_sym[i] = tbl_sym[i-1];
            tbl_freq[i] = tbl_freq[i-1];
          end
          tbl_sym[c.pos-1] = kmer_key(c);
          tbl_freq[c.pos-1] = f;
          tbl_len++;
        end
      end
      OpDelete: begin
        if (c.pos >= tbl_len) r.status = StBadPos;
        else begin
          for (int i = c.pos; i + 1 < tbl_len; i++) begin
            tbl_sym[i] = tbl_sym[i+1];
            tbl_freq[i] = tbl_freq[i+1];
          end
          tbl_len--;
        end
      end
      OpRead: begin
        if (c.pos >= tbl_len) r.status = StBadPos;
        else begin
          r.index = c.pos[11:0];
          r.symbols = tbl_sym[c.pos];
          r.frequency = tbl_freq[c.pos];
        end
      end
      OpFind: begin
        if (c.pos >= Depth) r.status = StBadPos;
        else begin
          r.status = StNotFound;
          for (int i = c.pos; i < tbl_len; i++)
            if (tbl_sym[i] == kmer_key(c)) begin
              r.status = StOk;
              r.index = i[11:0];
              r.symbols = tbl_sym[i];
              r.frequency = tbl_freq[i];
              break;
            end
        end
      end
      OpSort: begin
        for (int i = 0; i < tbl_len; i++) begin
          best = i;
          for (int j = i; j < tbl_len; j++)
            if (tbl_freq[j] > tbl_freq[best]) best = j;
          ts = tbl_sym[i]; tf = tbl_freq[i];
          tbl_sym[i] = tbl_sym[best]; tbl_freq[i] = tbl_freq[best];
          tbl_sym[best] = ts; tbl_freq[best] = tf;
        end
      end
      OpMerge: begin
        for (int i = 0; i < tbl_len; i++) begin
          w = i + 1;
          for (int j = i + 1; j < tbl_len; j++) begin
            if (tbl_sym[j] == tbl_sym[i]) tbl_freq[i] = add_clip(tbl_freq[i], tbl_freq[j]);
            else begin
              tbl_sym[w] = tbl_sym[j];
              tbl_freq[w] = tbl_freq[j];
              w++;
            end
          end
          tbl_len = w;
        end
        w = 0;
        for (int j = 0; j < tbl_len; j++)
          if (tbl_freq[j] != 0) begin
            tbl_sym[w] = tbl_sym[j];
            tbl_freq[w] = tbl_freq[j];
            w++;
          end
        tbl_len = w;
      end
      default: begin
        n = 0;
        for (int i = 0; i < tbl_len; i++)
          if (tbl_freq[i] >= c.thresh) n++;
        r.count = n[12:0];
        return r;
      end
    endcase
    r.count = tbl_len[12:0];
    return r;
  endfunction

  function automatic cmd_t make_cmd(input op_e op, input string s, input int nc,
                                    input logic [31:0] freq, input int pos,
                                    input logic [31:0] thresh);
    cmd_t c;
    c.op = op;
    for (int i = 0; i < 5; i++) c.chars[i] = (i < s.len()) ? s[i] : 8'h00;
    c.nchars = nc[2:0];
    c.freq = freq;
    c.pos = pos[12:0];
    c.thresh = thresh;
    c.has_fixed = 1'b0;
    c.fixed = '0;
    return c;
  endfunction

  function automatic cmd_t with_result(input cmd_t c, input logic [1:0] st,
                                       input int cnt);
    c.has_fixed = 1'b1;
    c.fixed = '0;
    c.fixed.status = st;
    c.fixed.count = cnt[12:0];
    return c;
  endfunction

  task automatic add_row(input cmd_t c);
    directed_rows = {directed_rows, c};
  endtask

  // A small alphabet keeps duplicates common so that find and merge hit.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: return "a";
      1: return "T";
      2: return "g";
      3: return "C";
      4: return "_";
      5: return 8'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return "a";
          1:       return "c";
          2:       return "g";
          default: return "t";
        endcase
      end
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   w;
    w = $urandom_range(0, 99);
    if (w < 35) c.op = OpAppend;
    else if (w < 50) c.op = OpInsert;
    else if (w < 60) c.op = OpDelete;
    else if (w < 72) c.op = OpRead;
    else if (w < 84) c.op = OpFind;
    else if (w < 88) c.op = OpSort;
    else if (w < 92) c.op = OpMerge;
    else c.op = OpCount;
    for (int i = 0; i < 5; i++) c.chars[i] = pick_char();
    c.nchars = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'd5;
    case ($urandom_range(0, 5))
      0: c.freq = $urandom;
      1: c.freq = 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: c.freq = 32'd0;
      default: c.freq = $urandom_range(0, 50);
    endcase
    if ($urandom_range(0, 7) == 0) c.pos = 13'($urandom);
    else c.pos = 13'($urandom_range(0, tbl_len + 1));
    c.thresh = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50);
    c.has_fixed = 1'b0;
    c.fixed = '0;
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    result_t r;
    r = table_step(c);
    if (c.has_fixed && r != c.fixed) begin
      $error("directed row disagrees with table: op %0d", c.op);
      errors++;
    end
    pending_results = {pending_results, r};
    op_hits[c.op]++;
    s_axis_tdata <= {8'd0, c.thresh, c.pos, c.freq, c.nchars,
                     c.chars[4], c.chars[3], c.chars[2], c.chars[1], c.chars[0]};
    s_axis_tuser <= c.op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_cycles(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Receiver: stall pattern, with one long hold-off on request.
  initial begin
    int phase;
    int held;
    phase = 0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        held++;
        if (held == 200) begin
          long_hold = 1'b0;
          held = 0;
        end
      end else begin
        phase = (phase + 1) % 23;
        m_axis_tready <= (phase < 12) ? 1'b1 : (phase < 17) ? 1'b0 : $urandom_range(0, 1);
      end
    end
  end

  // Result check.
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[73:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); errors++;
        end
        if (got.index != want.index) begin
          $error("index_out: expected %0d, got %0d", want.index, got.index); errors++;
        end
        if (got.symbols != want.symbols) begin
          $error("symbols_out: expected %h, got %h", want.symbols, got.symbols); errors++;
        end
        if (got.frequency != want.frequency) begin
          $error("frequency_out: expected %0d, got %0d", want.frequency, got.frequency);
          errors++;
        end
        if (got.count != want.count) begin
          $error("count_out: expected %0d, got %0d", want.count, got.count); errors++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    cmd_t c;
    int   burst;
    tbl_len = 0;
    // Fresh table: reads, deletes and finds miss; slot zero is illegal.
    add_row(with_result(make_cmd(OpRead, "", 0, 0, 0, 0), StBadPos, 0));
    add_row(with_result(make_cmd(OpDelete, "", 0, 0, 0, 0), StBadPos, 0));
    add_row(with_result(make_cmd(OpFind, "aaaaa", 5, 0, 0, 0), StNotFound, 0));
    add_row(with_result(make_cmd(OpFind, "aaaaa", 5, 0, 4096, 0), StBadPos, 0));
    add_row(with_result(make_cmd(OpFind, "aaaaa", 5, 0, 8191, 0), StBadPos, 0));
    add_row(with_result(make_cmd(OpInsert, "a", 1, 1, 0, 0), StBadPos, 0));
    add_row(with_result(make_cmd(OpInsert, "a", 1, 1, 2, 0), StBadPos, 0));
    add_row(with_result(make_cmd(OpCount, "", 0, 0, 0, 0), StOk, 0));
    add_row(with_result(make_cmd(OpSort, "", 0, 0, 0, 0), StOk, 0));
    add_row(with_result(make_cmd(OpMerge, "", 0, 0, 0, 0), StOk, 0));
    // Case folding, invalid characters, short and over-long counts, clamping.
    add_row(with_result(make_cmd(OpAppend, "AtGcX", 5, 32'h8000_0000, 0, 0), StOk, 1));
    add_row(with_result(make_cmd(OpAppend, "gg", 2, 32'h7FFF_FFFF, 0, 0), StOk, 2));
    add_row(with_result(make_cmd(OpAppend, "gg\xff\x00", 7, 32'h7FFF_FFFF, 0, 0),
                        StOk, 3));
    add_row(with_result(make_cmd(OpInsert, "ccccc", 5, 32'hFFFF_FFFF, 1, 0), StOk, 4));
    add_row(with_result(make_cmd(OpInsert, "tTtTt", 5, 5, 5, 0), StOk, 5));
    add_row(make_cmd(OpRead, "", 0, 0, 4, 0));
    add_row(make_cmd(OpFind, "GG", 2, 0, 0, 0));
    add_row(make_cmd(OpFind, "gg", 2, 0, 3, 0));
    add_row(with_result(make_cmd(OpCount, "", 0, 0, 0, 32'hFFFF_FFFF), StOk, 0));
    // Merge folds the two gg entries together and drops zero entries.
    add_row(make_cmd(OpMerge, "", 0, 0, 0, 0));
    add_row(make_cmd(OpRead, "", 0, 0, 0, 0));
    add_row(make_cmd(OpSort, "", 0, 0, 0, 0));
    add_row(make_cmd(OpRead, "", 0, 0, 0, 0));
    add_row(make_cmd(OpDelete, "", 0, 0, 0, 0));
    add_row(with_result(make_cmd(OpCount, "", 0, 0, 0, 0), StOk, 1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i]);
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 4));
    end

    for (int n = 0; n < NumRandom; n++) begin
      c = random_cmd();
      send_cmd(c);
      if (n == 40) begin
        // Hold the receiver off while items keep coming.
        long_hold = 1'b1;
        for (int k = 0; k < 3; k++) send_cmd(make_cmd(OpAppend, "acgta", 5, k, 0, 0));
      end
      if (n == 90) begin
        // Drain fully before continuing.
        idle_cycles(0);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      burst = $urandom_range(0, 4);
      if (burst == 0) idle_cycles($urandom_range(1, 8));
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("run: %0d results checked; ops append %0d insert %0d delete %0d read %0d",
             results_seen, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
    $display("     find %0d sort %0d merge %0d count %0d, final table size %0d",
             op_hits[4], op_hits[5], op_hits[6], op_hits[7], tbl_len);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### files.f
rtl/kft_pkg.sv
rtl/kft_mem.sv
rtl/kft_seq.sv
rtl/kmer_frequency_table_core.sv
sim/testbench.sv
